// ----- hw/rtl/bfba_pkg.sv -----
// Shared types and constants of the best-fit block allocator.
`timescale 1ns / 1ps

package bfba_pkg;

  localparam int unsigned SizeW  = 16;
  localparam int unsigned IndexW = 4;
  localparam int unsigned ReqW   = 16;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NO_FIT = 2'd1,
    ST_FULL   = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_RESULT
  } state_e;

  typedef struct packed {
    status_e             status;
    logic [IndexW-1:0]   block_index;
    logic [SizeW-1:0]    size_before;
    logic [SizeW-1:0]    size_left;
    logic [ReqW-1:0]     request_number;
  } res_t;

endpackage

// ----- hw/rtl/bfba_if.sv -----
// Handshake channels for request items and result items.
`timescale 1ns / 1ps

interface bfba_req_if;
  logic                         valid;
  logic                         ready;
  logic                         func;
  logic [bfba_pkg::SizeW-1:0]   size;

  modport source (output valid, func, size, input ready);
  modport sink (input valid, func, size, output ready);
endinterface

interface bfba_res_if;
  logic                          valid;
  logic                          ready;
  bfba_pkg::status_e             status;
  logic [bfba_pkg::IndexW-1:0]   block_index;
  logic [bfba_pkg::SizeW-1:0]    size_before;
  logic [bfba_pkg::SizeW-1:0]    size_left;
  logic [bfba_pkg::ReqW-1:0]     request_number;

  modport source (output valid, status, block_index, size_before, size_left,
                  request_number, input ready);
  modport sink (input valid, status, block_index, size_before, size_left,
                request_number, output ready);
endinterface

// ----- hw/rtl/bfba_mem.sv -----
// Free-size table: one write port, one read port with registered read data.
`timescale 1ns / 1ps

module bfba_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/bfba_ctrl.sv -----
// Sequencer: loads entries, scans the table for the best fit, writes back.
`timescale 1ns / 1ps

module bfba_ctrl #(
  parameter int unsigned MAX_BLOCKS = 16,
  parameter int unsigned SIZE_BITS  = 16,
  localparam int unsigned IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1,
  localparam int unsigned LW = $clog2(MAX_BLOCKS + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 req_valid_i,
  output logic                 req_ready_o,
  input  logic                 req_func_i,
  input  logic [SIZE_BITS-1:0] req_size_i,
  output logic                 mem_we_o,
  output logic [IW-1:0]        mem_waddr_o,
  output logic [SIZE_BITS-1:0] mem_wdata_o,
  output logic [IW-1:0]        mem_raddr_o,
  input  logic [SIZE_BITS-1:0] mem_rdata_i,
  output logic                 res_push_o,
  output bfba_pkg::res_t       res_o,
  input  logic                 slot_free_i
);

  import bfba_pkg::*;

  state_e               state_q, state_d;
  logic                 func_q, func_d;
  logic [SIZE_BITS-1:0] size_q, size_d;
  logic [LW-1:0]        loaded_q, loaded_d;
  logic [ReqW-1:0]      req_q, req_d;
  logic [LW-1:0]        rd_ptr_q, rd_ptr_d;
  logic [IW-1:0]        cmp_idx_q, cmp_idx_d;
  logic                 found_q, found_d;
  logic [IW-1:0]        best_idx_q, best_idx_d;
  logic [SIZE_BITS-1:0] best_val_q, best_val_d;

  logic                 accept;
  logic                 full;
  logic                 last;
  logic                 take;
  logic [SIZE_BITS-1:0] place_left;
  logic [31:0]          idx_ext;
  logic [31:0]          before_ext;
  logic [31:0]          left_ext;

  assign accept     = req_valid_i && (state_q == S_IDLE);
  assign full       = (loaded_q == LW'(MAX_BLOCKS));
  assign last       = ((LW'(cmp_idx_q) + LW'(1)) == loaded_q);
  // Strict less-than keeps the lowest index among equal sizes.
  assign take       = (mem_rdata_i >= size_q) && (!found_q || (mem_rdata_i < best_val_q));
  assign place_left = best_val_q - size_q;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (req_func_i && (loaded_q != '0)) begin
            state_d = S_SCAN;
          end else begin
            state_d = S_RESULT;
          end
        end
      end
      S_SCAN: begin
        if (last) begin
          state_d = S_RESULT;
        end
      end
      S_RESULT: begin
        if (slot_free_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath registers.
  always_comb begin
    func_d     = func_q;
    size_d     = size_q;
    loaded_d   = loaded_q;
    req_d      = req_q;
    rd_ptr_d   = rd_ptr_q;
    cmp_idx_d  = cmp_idx_q;
    found_d    = found_q;
    best_idx_d = best_idx_q;
    best_val_d = best_val_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          func_d    = req_func_i;
          size_d    = req_size_i;
          rd_ptr_d  = LW'(1);
          cmp_idx_d = '0;
          if (!req_func_i) begin
            found_d    = !full;
            best_idx_d = loaded_q[IW-1:0];
            if (!full) begin
              loaded_d = loaded_q + LW'(1);
            end
          end else begin
            req_d   = req_q + ReqW'(1);
            found_d = 1'b0;
          end
        end
      end
      S_SCAN: begin
        rd_ptr_d  = rd_ptr_q + LW'(1);
        cmp_idx_d = cmp_idx_q + IW'(1);
        if (take) begin
          found_d    = 1'b1;
          best_idx_d = cmp_idx_q;
          best_val_d = mem_rdata_i;
        end
      end
      default: ;
    endcase
  end

  // Outputs.
  always_comb begin
    req_ready_o = 1'b0;
    mem_we_o    = 1'b0;
    mem_waddr_o = loaded_q[IW-1:0];
    mem_wdata_o = req_size_i;
    mem_raddr_o = '0;
    res_push_o  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        mem_we_o    = accept && !req_func_i && !full;
      end
      S_SCAN: begin
        if (rd_ptr_q < loaded_q) begin
          mem_raddr_o = rd_ptr_q[IW-1:0];
        end
      end
      S_RESULT: begin
        res_push_o = slot_free_i;
        // Rewriting the same value while the result waits is harmless.
        if (func_q && found_q) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = best_idx_q;
          mem_wdata_o = place_left;
        end
      end
      default: ;
    endcase
  end

  // Result fields, formed from the registers held in the result state.
  always_comb begin
    idx_ext    = found_q ? 32'(best_idx_q) : 32'd0;
    before_ext = (func_q && found_q) ? 32'(best_val_q) : 32'd0;
    if (!found_q) begin
      left_ext = 32'd0;
    end else if (func_q) begin
      left_ext = 32'(place_left);
    end else begin
      left_ext = 32'(size_q);
    end
    if (found_q) begin
      res_o.status = ST_OK;
    end else if (func_q) begin
      res_o.status = ST_NO_FIT;
    end else begin
      res_o.status = ST_FULL;
    end
    res_o.block_index    = idx_ext[IndexW-1:0];
    res_o.size_before    = before_ext[SizeW-1:0];
    res_o.size_left      = left_ext[SizeW-1:0];
    res_o.request_number = func_q ? req_q : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      loaded_q <= '0;
      req_q    <= '0;
      found_q  <= 1'b0;
      func_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      loaded_q <= loaded_d;
      req_q    <= req_d;
      found_q  <= found_d;
      func_q   <= func_d;
    end
  end

  always_ff @(posedge clk_i) begin
    size_q     <= size_d;
    rd_ptr_q   <= rd_ptr_d;
    cmp_idx_q  <= cmp_idx_d;
    best_idx_q <= best_idx_d;
    best_val_q <= best_val_d;
  end

endmodule

// ----- hw/rtl/best_fit_block_allocator.sv -----
// Best-fit block allocator: a table of free block sizes is filled by load
// items, and each place item takes its request from the smallest block that
// still fits (lowest index on ties), reporting index, size before, size left
// and a running request number. One result comes back per item. A load goes
// straight from idle to the result state; a place with blocks loaded first
// scans them, reading the free-size memory through its single read port
// one entry per cycle. A finished result sits in an output register, so the
// next item is taken while it waits.
`timescale 1ns / 1ps

module best_fit_block_allocator #(
  parameter int unsigned MAX_BLOCKS = 16,
  parameter int unsigned SIZE_BITS  = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  bfba_req_if.sink    req_i,
  bfba_res_if.source  res_o
);

  import bfba_pkg::*;

  localparam int unsigned IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;

  logic [31:0]          size_ext;
  logic [SIZE_BITS-1:0] size_in;
  logic                 mem_we;
  logic [IW-1:0]        mem_waddr;
  logic [SIZE_BITS-1:0] mem_wdata;
  logic [IW-1:0]        mem_raddr;
  logic [SIZE_BITS-1:0] mem_rdata;
  logic                 res_push;
  res_t                 res_new;
  logic                 slot_free;
  logic                 out_valid_q, out_valid_d;
  res_t                 out_q;

  // Sizes are taken modulo 2^SIZE_BITS.
  assign size_ext = 32'(req_i.size);
  assign size_in  = size_ext[SIZE_BITS-1:0];

  bfba_mem #(
    .DEPTH (MAX_BLOCKS),
    .WIDTH (SIZE_BITS)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  bfba_ctrl #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .SIZE_BITS  (SIZE_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .req_func_i  (req_i.func),
    .req_size_i  (size_in),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata),
    .res_push_o  (res_push),
    .res_o       (res_new),
    .slot_free_i (slot_free)
  );

  // Output register: free when empty or when its transfer completes now.
  assign slot_free = !out_valid_q || res_o.ready;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_push) begin
      out_valid_d = 1'b1;
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_push) begin
      out_q <= res_new;
    end
  end

  assign res_o.valid          = out_valid_q;
  assign res_o.status         = out_q.status;
  assign res_o.block_index    = out_q.block_index;
  assign res_o.size_before    = out_q.size_before;
  assign res_o.size_left      = out_q.size_left;
  assign res_o.request_number = out_q.request_number;

endmodule

// ----- dv/tb_best_fit_block_allocator.sv -----
// Testbench for the best-fit block allocator, checked against a model of the free-size table.
`timescale 1ns / 1ps

module tb_best_fit_block_allocator;
  import bfba_pkg::*;

  localparam bit          FUNC_LOAD  = 1'b0;
  localparam bit          FUNC_PLACE = 1'b1;
  localparam int unsigned TableDepth = 16;

  typedef struct {
    bit               func;
    logic [SizeW-1:0] size;
    bit               drain_first;
  } alloc_item_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  bfba_req_if req_if ();
  bfba_res_if res_if ();

  best_fit_block_allocator u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .res_o  (res_if)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  alloc_item_t      request_items[$];
  res_t             awaited_results[$];
  int               items_sent;
  int               results_seen;
  int               errors;
  int               stall_left;
  bit               long_stall_done;

  // Predictor's copy of the allocator state.
  logic [SizeW-1:0] model_sizes[TableDepth];
  int unsigned      model_loaded;
  logic [ReqW-1:0]  model_requests;

  function automatic res_t predict_allocation(bit func, logic [SizeW-1:0] sz);
    res_t r;
    int   best;
    r    = '0;
    best = -1;
    if (func == FUNC_LOAD) begin
      if (model_loaded >= TableDepth) begin
        r.status = ST_FULL;
      end else begin
        model_sizes[model_loaded] = sz;
        r.status      = ST_OK;
        r.block_index = IndexW'(model_loaded);
        r.size_left   = sz;
        model_loaded++;
      end
    end else begin
      model_requests++;
      r.request_number = model_requests;
      for (int i = 0; i < model_loaded; i++) begin
        if (model_sizes[i] >= sz && (best < 0 || model_sizes[i] < model_sizes[best])) begin
          best = i;
        end
      end
      if (best < 0) begin
        r.status = ST_NO_FIT;
      end else begin
        r.status          = ST_OK;
        r.block_index     = IndexW'(best);
        r.size_before     = model_sizes[best];
        r.size_left       = model_sizes[best] - sz;
        model_sizes[best] = model_sizes[best] - sz;
      end
    end
    return r;
  endfunction

  function automatic void add_item(bit func, logic [SizeW-1:0] sz, bit drain_first = 1'b0);
    alloc_item_t it;
    it.func        = func;
    it.size        = sz;
    it.drain_first = drain_first;
    request_items.push_back(it);
  endfunction

  task automatic check_result();
    res_t want;
    if (awaited_results.size() == 0) begin
      $error("result with no expectation: status %0d index %0d", res_if.status,
             res_if.block_index);
      errors++;
    end else begin
      want = awaited_results.pop_front();
      if (res_if.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, res_if.status);
        errors++;
      end
      if (res_if.block_index !== want.block_index) begin
        $error("block_index: expected %0d, actual %0d", want.block_index, res_if.block_index);
        errors++;
      end
      if (res_if.size_before !== want.size_before) begin
        $error("size_before: expected %0d, actual %0d", want.size_before, res_if.size_before);
        errors++;
      end
      if (res_if.size_left !== want.size_left) begin
        $error("size_left: expected %0d, actual %0d", want.size_left, res_if.size_left);
        errors++;
      end
      if (res_if.request_number !== want.request_number) begin
        $error("request_number: expected %0d, actual %0d", want.request_number,
               res_if.request_number);
        errors++;
      end
    end
  endtask

  // Sender: the expectation is computed at the transfer; an item marked drain_first
  // waits until every outstanding result has come back.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      req_if.func  <= FUNC_LOAD;
      req_if.size  <= '0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        awaited_results.push_back(predict_allocation(req_if.func, req_if.size));
        items_sent++;
      end
      if (!req_if.valid || req_if.ready) begin
        if (request_items.size() != 0 &&
            !(request_items[0].drain_first && awaited_results.size() != 0) &&
            ((items_sent >= 350 && items_sent <= 450) || $urandom_range(99) >= 23)) begin
          req_if.valid <= 1'b1;
          req_if.func  <= request_items[0].func;
          req_if.size  <= request_items[0].size;
          request_items.pop_front();
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random back-pressure, one long hold-off, and a calm stretch.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        check_result();
        results_seen++;
      end
      if (stall_left != 0) begin
        stall_left--;
        res_if.ready <= 1'b0;
      end else if (results_seen == 200 && !long_stall_done) begin
        long_stall_done = 1'b1;
        stall_left      = 120;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= (results_seen >= 350 && results_seen <= 450) ||
                        $urandom_range(99) >= 23;
      end
    end
  end

  initial begin
    logic [SizeW-1:0] sz;
    rst_ni = 1'b0;

    // Empty table, zero-size block, ties, exact fits and the field extremes.
    add_item(FUNC_PLACE, 16'd0);
    add_item(FUNC_PLACE, 16'hFFFF);
    add_item(FUNC_LOAD, 16'd0);
    add_item(FUNC_PLACE, 16'd0);
    add_item(FUNC_PLACE, 16'd1);
    add_item(FUNC_LOAD, 16'hFFFF);
    add_item(FUNC_LOAD, 16'd100);
    add_item(FUNC_LOAD, 16'd100);
    add_item(FUNC_PLACE, 16'd100);
    add_item(FUNC_PLACE, 16'd50);
    add_item(FUNC_PLACE, 16'd50);
    add_item(FUNC_PLACE, 16'hFFFF);
    add_item(FUNC_PLACE, 16'd0);
    add_item(FUNC_LOAD, 16'hAAAA);
    add_item(FUNC_LOAD, 16'h5555);
    add_item(FUNC_PLACE, 16'h5555);
    add_item(FUNC_PLACE, 16'hAAAB);
    add_item(FUNC_PLACE, 16'h2AAA);

    // Loads are rare so that the table fills slowly and later loads hit a full table.
    for (int n = 0; n < 650; n++) begin
      if ($urandom_range(99) < 6) begin
        case ($urandom_range(3))
          0:       sz = SizeW'($urandom_range(999));
          1:       sz = SizeW'($urandom_range(65535, 40000));
          default: sz = SizeW'($urandom);
        endcase
        add_item(FUNC_LOAD, sz, n == 500);
      end else begin
        case ($urandom_range(99)) inside
          [0:7]:   sz = '0;
          [8:14]:  sz = SizeW'($urandom);
          [15:29]: sz = SizeW'($urandom_range(4000));
          default: sz = SizeW'($urandom_range(300));
        endcase
        add_item(FUNC_PLACE, sz, n == 0 || n == 500);
      end
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (request_items.size() != 0 || req_if.valid || awaited_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (40) @(posedge clk_i);
    if (errors == 0) begin
      $display("best_fit_block_allocator test passed");
    end else begin
      $display("best_fit_block_allocator test failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("best_fit_block_allocator test failed");
    $finish;
  end

endmodule
